// ===== rtl/jfhs_pkg.sv =====
// jfhs_pkg.sv: shared types, codes and byte constants of the jpeg frame header scanner
`timescale 1ns / 1ps

package jfhs_pkg;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NO_SOI  = 3'd1;
  localparam logic [2:0] ST_NO_EOI  = 3'd2;
  localparam logic [2:0] ST_BAD     = 3'd3;
  localparam logic [2:0] ST_EARLY   = 3'd4;
  localparam logic [2:0] ST_NOFRAME = 3'd5;

  // marker bytes
  localparam logic [7:0] MK_FF  = 8'hFF;
  localparam logic [7:0] MK_SOI = 8'hD8;
  localparam logic [7:0] MK_EOI = 8'hD9;
  localparam logic [7:0] MK_TEM = 8'h01;
  localparam logic [7:0] MK_RST0 = 8'hD0;
  localparam logic [7:0] MK_RST7 = 8'hD7;
  localparam logic [7:0] MK_SOF0 = 8'hC0;
  localparam logic [7:0] MK_SOF1 = 8'hC1;
  localparam logic [7:0] MK_SOF2 = 8'hC2;
  localparam logic [7:0] MK_SOF3 = 8'hC3;
  localparam logic [7:0] MK_SOF9 = 8'hC9;
  localparam logic [7:0] MK_SOF10 = 8'hCA;
  localparam logic [7:0] MK_SOF11 = 8'hCB;

  // shortest legal segment lengths
  localparam logic [15:0] MIN_SEG_LEN = 16'd2;
  localparam logic [15:0] MIN_SOF_LEN = 16'd7;

  // request queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    PH_SOI1,
    PH_SOI2,
    PH_MARK_FF,
    PH_MARK,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_SKIP,
    PH_SOF_P,
    PH_SOF_H1,
    PH_SOF_H2,
    PH_SOF_W1,
    PH_SOF_W2,
    PH_TAIL,
    PH_DEAD
  } phase_t;

  // one classified request as it travels from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_ff;
    logic       is_soi;
    logic       is_eoi;
    logic       is_zero;
    logic       is_standalone;
    logic       is_frame;
    logic       is_420;
  } req_t;

endpackage

// ===== rtl/jfhs_front.sv =====
// jfhs_front.sv: accepts bytes, classifies them and queues them for the walker
`timescale 1ns / 1ps

module jfhs_front #(
  parameter int Depth = jfhs_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_data_byte,
  input  logic           in_final_byte,
  output logic           q_valid,
  output jfhs_pkg::req_t q_req,
  input  logic           q_pop
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  jfhs_pkg::req_t       entry_r [Depth];
  logic [PtrW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]      count_r, count_nxt;
  jfhs_pkg::req_t       cls;
  logic                 push;

  always_comb begin
    cls.data          = in_data_byte;
    cls.last          = in_final_byte;
    cls.is_ff         = (in_data_byte == jfhs_pkg::MK_FF);
    cls.is_soi        = (in_data_byte == jfhs_pkg::MK_SOI);
    cls.is_eoi        = (in_data_byte == jfhs_pkg::MK_EOI);
    cls.is_zero       = (in_data_byte == 8'h00);
    cls.is_standalone = (in_data_byte == jfhs_pkg::MK_TEM) ||
                        ((in_data_byte >= jfhs_pkg::MK_RST0) &&
                         (in_data_byte <= jfhs_pkg::MK_RST7));
    cls.is_frame      = (in_data_byte == jfhs_pkg::MK_SOF0) ||
                        (in_data_byte == jfhs_pkg::MK_SOF1) ||
                        (in_data_byte == jfhs_pkg::MK_SOF2) ||
                        (in_data_byte == jfhs_pkg::MK_SOF3) ||
                        (in_data_byte == jfhs_pkg::MK_SOF9) ||
                        (in_data_byte == jfhs_pkg::MK_SOF10) ||
                        (in_data_byte == jfhs_pkg::MK_SOF11);
    cls.is_420        = (in_data_byte == jfhs_pkg::MK_SOF0) ||
                        (in_data_byte == jfhs_pkg::MK_SOF2);
  end

  assign in_ready = (count_r != CntW'(Depth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign q_req    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CntW'(push) - CntW'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== rtl/jfhs_walker.sv =====
// jfhs_walker.sv: marker segment walker and result register
`timescale 1ns / 1ps

module jfhs_walker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  jfhs_pkg::req_t q_req,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     out_status,
  output logic [15:0]    out_frame_height,
  output logic [15:0]    out_frame_width,
  output logic           out_chroma_420,
  output logic [7:0]     out_frame_marker
);

  jfhs_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [7:0]  marker_r, marker_nxt;
  logic        frame_r, frame_nxt;
  logic        c420_r, c420_nxt;
  logic [15:0] height_r, height_nxt;
  logic [15:0] width_r, width_nxt;
  logic [2:0]  verdict_r, verdict_nxt;
  logic        prev_ff_r;
  logic [15:0] seg_len;
  logic        soi_bad, tail_ok, found;
  logic [2:0]  status_c;
  logic        out_valid_r;
  logic        finish;

  assign out_valid = out_valid_r;
  assign q_pop  = q_valid && (!q_req.last || !out_valid_r || out_ready);
  assign finish = q_pop && q_req.last;
  assign seg_len = {len_hi_r, q_req.data};

  always_comb begin
    phase_nxt   = phase_r;
    skip_nxt    = skip_r;
    len_hi_nxt  = len_hi_r;
    marker_nxt  = marker_r;
    frame_nxt   = frame_r;
    c420_nxt    = c420_r;
    height_nxt  = height_r;
    width_nxt   = width_r;
    verdict_nxt = verdict_r;
    case (phase_r)
      jfhs_pkg::PH_SOI1: begin
        if (q_req.is_ff) begin
          phase_nxt = jfhs_pkg::PH_SOI2;
        end else begin
          verdict_nxt = jfhs_pkg::ST_NO_SOI;
          phase_nxt   = jfhs_pkg::PH_DEAD;
        end
      end
      jfhs_pkg::PH_SOI2: begin
        if (q_req.is_soi) begin
          phase_nxt = jfhs_pkg::PH_MARK_FF;
        end else begin
          verdict_nxt = jfhs_pkg::ST_NO_SOI;
          phase_nxt   = jfhs_pkg::PH_DEAD;
        end
      end
      jfhs_pkg::PH_MARK_FF: begin
        if (q_req.is_ff) begin
          phase_nxt = jfhs_pkg::PH_MARK;
        end else begin
          verdict_nxt = jfhs_pkg::ST_BAD;
          phase_nxt   = jfhs_pkg::PH_DEAD;
        end
      end
      jfhs_pkg::PH_MARK: begin
        if (q_req.is_ff) begin
          phase_nxt = jfhs_pkg::PH_MARK;  // fill byte
        end else if (q_req.is_eoi) begin
          verdict_nxt = jfhs_pkg::ST_EARLY;
          phase_nxt   = jfhs_pkg::PH_DEAD;
        end else if (q_req.is_zero || q_req.is_soi) begin
          verdict_nxt = jfhs_pkg::ST_BAD;
          phase_nxt   = jfhs_pkg::PH_DEAD;
        end else if (q_req.is_standalone) begin
          phase_nxt = jfhs_pkg::PH_MARK_FF;
        end else begin
          marker_nxt = q_req.data;
          frame_nxt  = q_req.is_frame;
          c420_nxt   = q_req.is_420;
          phase_nxt  = jfhs_pkg::PH_LEN_HI;
        end
      end
      jfhs_pkg::PH_LEN_HI: begin
        len_hi_nxt = q_req.data;
        phase_nxt  = jfhs_pkg::PH_LEN_LO;
      end
      jfhs_pkg::PH_LEN_LO: begin
        if (seg_len < jfhs_pkg::MIN_SEG_LEN) begin
          verdict_nxt = jfhs_pkg::ST_BAD;
          phase_nxt   = jfhs_pkg::PH_DEAD;
        end else if (frame_r) begin
          if (seg_len < jfhs_pkg::MIN_SOF_LEN) begin
            verdict_nxt = jfhs_pkg::ST_BAD;
            phase_nxt   = jfhs_pkg::PH_DEAD;
          end else begin
            phase_nxt = jfhs_pkg::PH_SOF_P;
          end
        end else begin
          skip_nxt  = seg_len - jfhs_pkg::MIN_SEG_LEN;
          phase_nxt = (seg_len == jfhs_pkg::MIN_SEG_LEN) ? jfhs_pkg::PH_MARK_FF
                                                         : jfhs_pkg::PH_SKIP;
        end
      end
      jfhs_pkg::PH_SKIP: begin
        skip_nxt = skip_r - 16'd1;
        if (skip_r == 16'd1) begin
          phase_nxt = jfhs_pkg::PH_MARK_FF;
        end
      end
      jfhs_pkg::PH_SOF_P: begin
        phase_nxt = jfhs_pkg::PH_SOF_H1;
      end
      jfhs_pkg::PH_SOF_H1: begin
        height_nxt = {q_req.data, 8'h00};
        phase_nxt  = jfhs_pkg::PH_SOF_H2;
      end
      jfhs_pkg::PH_SOF_H2: begin
        height_nxt = {height_r[15:8], q_req.data};
        phase_nxt  = jfhs_pkg::PH_SOF_W1;
      end
      jfhs_pkg::PH_SOF_W1: begin
        width_nxt = {q_req.data, 8'h00};
        phase_nxt = jfhs_pkg::PH_SOF_W2;
      end
      jfhs_pkg::PH_SOF_W2: begin
        width_nxt   = {width_r[15:8], q_req.data};
        verdict_nxt = jfhs_pkg::ST_OK;
        phase_nxt   = jfhs_pkg::PH_TAIL;
      end
      default: begin
        phase_nxt = phase_r;  // tail watch or latched error
      end
    endcase

    soi_bad = (verdict_nxt == jfhs_pkg::ST_NO_SOI) ||
              (phase_nxt == jfhs_pkg::PH_SOI1) || (phase_nxt == jfhs_pkg::PH_SOI2);
    tail_ok = prev_ff_r && q_req.is_eoi;
    found   = (verdict_nxt == jfhs_pkg::ST_OK);
    if (soi_bad) begin
      status_c = jfhs_pkg::ST_NO_SOI;
    end else if (!tail_ok) begin
      status_c = jfhs_pkg::ST_NO_EOI;
    end else begin
      status_c = verdict_nxt;
    end
  end

  // walker state, back to reset values after the last byte of an image
  always_ff @(posedge clk) begin
    if (!rst_n || finish) begin
      phase_r   <= jfhs_pkg::PH_SOI1;
      skip_r    <= '0;
      len_hi_r  <= '0;
      marker_r  <= '0;
      frame_r   <= 1'b0;
      c420_r    <= 1'b0;
      height_r  <= '0;
      width_r   <= '0;
      verdict_r <= jfhs_pkg::ST_NOFRAME;
      prev_ff_r <= 1'b0;
    end else if (q_pop) begin
      phase_r   <= phase_nxt;
      skip_r    <= skip_nxt;
      len_hi_r  <= len_hi_nxt;
      marker_r  <= marker_nxt;
      frame_r   <= frame_nxt;
      c420_r    <= c420_nxt;
      height_r  <= height_nxt;
      width_r   <= width_nxt;
      verdict_r <= verdict_nxt;
      prev_ff_r <= q_req.is_ff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_status       <= status_c;
      out_frame_height <= found ? height_nxt : 16'd0;
      out_frame_width  <= found ? width_nxt : 16'd0;
      out_chroma_420   <= found && c420_nxt;
      out_frame_marker <= found ? marker_nxt : 8'd0;
    end
  end

endmodule

// ===== rtl/jpeg_frame_header_scanner.sv =====
// jpeg_frame_header_scanner.sv: top level of the jpeg frame header scanner
`timescale 1ns / 1ps

// usage
// - input channel in_*: one image byte per request, in_final_byte high on the
//   last byte of the image; the next image may follow in the next cycle
// - result channel out_*: exactly one request per image, issued for its last
//   byte: status, frame height and width, 4:2:0 flag and frame marker code
// - throughput: one byte per cycle, sustained unless a stalled result holds
//   back a last byte; the walker state machine handles one byte per clock and
//   the front queue is two entries deep
// - result path: the last byte is written into the front queue, then the walker
//   pops it and loads the result register, which raises out_valid
// - reset (rst_n low, synchronous): queue empty, walker back to expecting the
//   start-of-image marker, no result pending
// - receiver stall: the result register holds its request; the walker keeps
//   consuming bytes of the next image and stops only at that image's last
//   byte, after which the queue fills and in_ready drops
// - after each last byte the walker returns to its reset state by itself
module jpeg_frame_header_scanner #(
  parameter int QueueDepth = jfhs_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [15:0] out_frame_height,
  output logic [15:0] out_frame_width,
  output logic        out_chroma_420,
  output logic [7:0]  out_frame_marker
);

  // classified bytes between front and back
  logic           q_valid;
  logic           q_pop;
  jfhs_pkg::req_t q_req;

  // front: accept and classify
  jfhs_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_final_byte(in_final_byte),
    .q_valid      (q_valid),
    .q_req        (q_req),
    .q_pop        (q_pop)
  );

  // back: walk segments, capture frame header, form result
  jfhs_walker u_walker (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_req           (q_req),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_frame_height(out_frame_height),
    .out_frame_width (out_frame_width),
    .out_chroma_420  (out_chroma_420),
    .out_frame_marker(out_frame_marker)
  );

endmodule

// ===== rtl/jfhs_checker.sv =====
// jfhs_checker.sv: port-level assertions for the jpeg frame header scanner
`timescale 1ns / 1ps

module jfhs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [15:0] out_frame_height,
  input logic [15:0] out_frame_width,
  input logic        out_chroma_420,
  input logic [7:0]  out_frame_marker
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_frame_height) && $stable(out_frame_width) &&
      $stable(out_frame_marker) && $stable(out_chroma_420))
    else $error("result changed while stalled");

  // ok status needs a captured frame marker
  a_ok_has_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == jfhs_pkg::ST_OK) |-> (out_frame_marker != 8'd0))
    else $error("ok status without frame marker");

  // no frame marker means all frame fields are zero
  a_no_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_frame_marker == 8'd0) |->
      (out_frame_height == 16'd0) && (out_frame_width == 16'd0) && !out_chroma_420)
    else $error("frame fields without frame marker");

  // 4:2:0 flag only for the two baseline/progressive huffman markers
  a_chroma_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_chroma_420 |->
      (out_frame_marker == jfhs_pkg::MK_SOF0) || (out_frame_marker == jfhs_pkg::MK_SOF2))
    else $error("4:2:0 flag with wrong marker");

  // a captured frame with a frame-stage verdict can only be ok or a tail error
  a_frame_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_frame_marker != 8'd0) |->
      (out_status == jfhs_pkg::ST_OK) || (out_status == jfhs_pkg::ST_NO_EOI))
    else $error("captured frame with unexpected status");

endmodule

bind jpeg_frame_header_scanner jfhs_checker u_jfhs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_frame_height(out_frame_height),
  .out_frame_width (out_frame_width),
  .out_chroma_420  (out_chroma_420),
  .out_frame_marker(out_frame_marker)
);

// ===== bench/jpeg_frame_header_scanner_tb.sv =====
// jpeg_frame_header_scanner_tb.sv: self-checking bench for the jpeg frame header scanner
`timescale 1ns / 1ps

module jpeg_frame_header_scanner_tb;

  // run bounds
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 20;
  localparam int TARGET_BYTES  = 1800;
  localparam int LONG_HOLD     = 400;

  // one image byte as queued for the driver
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       drain;   // hold off until every pending header has come back
  } jpeg_byte_t;

  // one scanned frame header as the result channel reports it
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] height;
    logic [15:0] width;
    logic        c420;
    logic [7:0]  marker;
  } header_info_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_final_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [15:0] out_frame_height;
  logic [15:0] out_frame_width;
  logic        out_chroma_420;
  logic [7:0]  out_frame_marker;

  jpeg_frame_header_scanner dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_final_byte    (in_final_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_frame_height (out_frame_height),
    .out_frame_width  (out_frame_width),
    .out_chroma_420   (out_chroma_420),
    .out_frame_marker (out_frame_marker)
  );

  // stimulus and expectation stores
  jpeg_byte_t   byte_queue[$];
  header_info_t due_headers[$];
  logic [7:0]   img[$];
  int           total_bytes  = 0;
  int           total_images = 0;

  // progress counters; the sent and seen counts use nonblocking writes so other blocks see stable values
  int bytes_sent   = 0;
  int finals_sent  = 0;
  int results_seen = 0;
  int errors       = 0;
  int cycle_count  = 0;
  int status_hits[6];

  // walker mirror
  jfhs_pkg::phase_t walk_phase;
  logic [15:0] bytes_left;
  logic [7:0]  len_high;
  logic [7:0]  seg_marker;
  logic [15:0] cap_height;
  logic [15:0] cap_width;
  logic [2:0]  parse_verdict;
  logic [7:0]  last_byte_seen;

  logic [7:0] sof_codes[7] = '{jfhs_pkg::MK_SOF0, jfhs_pkg::MK_SOF1, jfhs_pkg::MK_SOF2,
                               jfhs_pkg::MK_SOF3, jfhs_pkg::MK_SOF9, jfhs_pkg::MK_SOF10,
                               jfhs_pkg::MK_SOF11};

  // clock, 10 ns
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // single reset pulse
  initial begin
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic bit is_sof_code(input logic [7:0] c);
    return c == jfhs_pkg::MK_SOF0 || c == jfhs_pkg::MK_SOF1 || c == jfhs_pkg::MK_SOF2 ||
           c == jfhs_pkg::MK_SOF3 || c == jfhs_pkg::MK_SOF9 || c == jfhs_pkg::MK_SOF10 ||
           c == jfhs_pkg::MK_SOF11;
  endfunction

  function automatic bit is_standalone(input logic [7:0] c);
    return c == jfhs_pkg::MK_TEM || (c >= jfhs_pkg::MK_RST0 && c <= jfhs_pkg::MK_RST7);
  endfunction

  // idle share in percent per run phase: receiver-heavy, sender-heavy, none
  function automatic int idle_share(input int ph, input bit sender);
    case (ph)
      0: return sender ? 28 : 53;
      1: return sender ? 53 : 28;
      default: return 0;
    endcase
  endfunction

  task automatic clear_walker();
    walk_phase     = jfhs_pkg::PH_SOI1;
    bytes_left     = 16'd0;
    len_high       = 8'd0;
    seg_marker     = 8'd0;
    cap_height     = 16'd0;
    cap_width      = 16'd0;
    parse_verdict  = jfhs_pkg::ST_NOFRAME;
    last_byte_seen = 8'd0;
  endtask

  // first error wins, the rest of the image is ignored
  task automatic walk_fail(input logic [2:0] code);
    parse_verdict = code;
    walk_phase    = jfhs_pkg::PH_DEAD;
  endtask

  // advance the walker mirror by one byte; on the last byte queue the expected header
  task automatic scan_byte(input logic [7:0] b, input logic is_last);
    logic [7:0]   prev;
    logic [15:0]  seg_len;
    logic         soi_bad;
    logic         tail_ok;
    logic         found;
    header_info_t hdr;
    prev = last_byte_seen;
    case (walk_phase)
      jfhs_pkg::PH_SOI1: begin
        if (b == jfhs_pkg::MK_FF) walk_phase = jfhs_pkg::PH_SOI2;
        else walk_fail(jfhs_pkg::ST_NO_SOI);
      end
      jfhs_pkg::PH_SOI2: begin
        if (b == jfhs_pkg::MK_SOI) walk_phase = jfhs_pkg::PH_MARK_FF;
        else walk_fail(jfhs_pkg::ST_NO_SOI);
      end
      jfhs_pkg::PH_MARK_FF: begin
        if (b == jfhs_pkg::MK_FF) walk_phase = jfhs_pkg::PH_MARK;
        else walk_fail(jfhs_pkg::ST_BAD);
      end
      jfhs_pkg::PH_MARK: begin
        if (b == jfhs_pkg::MK_FF) begin
          // fill byte, stay put
        end else if (b == jfhs_pkg::MK_EOI) begin
          walk_fail(jfhs_pkg::ST_EARLY);
        end else if (b == 8'h00 || b == jfhs_pkg::MK_SOI) begin
          walk_fail(jfhs_pkg::ST_BAD);
        end else if (is_standalone(b)) begin
          walk_phase = jfhs_pkg::PH_MARK_FF;
        end else begin
          seg_marker = b;
          walk_phase = jfhs_pkg::PH_LEN_HI;
        end
      end
      jfhs_pkg::PH_LEN_HI: begin
        len_high   = b;
        walk_phase = jfhs_pkg::PH_LEN_LO;
      end
      jfhs_pkg::PH_LEN_LO: begin
        seg_len = {len_high, b};
        if (seg_len < jfhs_pkg::MIN_SEG_LEN) begin
          walk_fail(jfhs_pkg::ST_BAD);
        end else if (is_sof_code(seg_marker)) begin
          if (seg_len < jfhs_pkg::MIN_SOF_LEN) walk_fail(jfhs_pkg::ST_BAD);
          else walk_phase = jfhs_pkg::PH_SOF_P;
        end else begin
          bytes_left = seg_len - jfhs_pkg::MIN_SEG_LEN;
          walk_phase = (bytes_left == 16'd0) ? jfhs_pkg::PH_MARK_FF : jfhs_pkg::PH_SKIP;
        end
      end
      jfhs_pkg::PH_SKIP: begin
        bytes_left = bytes_left - 16'd1;
        if (bytes_left == 16'd0) walk_phase = jfhs_pkg::PH_MARK_FF;
      end
      jfhs_pkg::PH_SOF_P:  walk_phase = jfhs_pkg::PH_SOF_H1;
      jfhs_pkg::PH_SOF_H1: begin
        cap_height = {b, 8'h00};
        walk_phase = jfhs_pkg::PH_SOF_H2;
      end
      jfhs_pkg::PH_SOF_H2: begin
        cap_height[7:0] = b;
        walk_phase      = jfhs_pkg::PH_SOF_W1;
      end
      jfhs_pkg::PH_SOF_W1: begin
        cap_width  = {b, 8'h00};
        walk_phase = jfhs_pkg::PH_SOF_W2;
      end
      jfhs_pkg::PH_SOF_W2: begin
        cap_width[7:0] = b;
        parse_verdict  = jfhs_pkg::ST_OK;
        walk_phase     = jfhs_pkg::PH_TAIL;
      end
      default: begin
        // tail watch or dead: nothing to walk
      end
    endcase
    last_byte_seen = b;
    if (is_last) begin
      soi_bad = parse_verdict == jfhs_pkg::ST_NO_SOI || walk_phase == jfhs_pkg::PH_SOI1 ||
                walk_phase == jfhs_pkg::PH_SOI2;
      tail_ok = prev == jfhs_pkg::MK_FF && b == jfhs_pkg::MK_EOI;
      found   = parse_verdict == jfhs_pkg::ST_OK;
      if (soi_bad) hdr.status = jfhs_pkg::ST_NO_SOI;
      else if (!tail_ok) hdr.status = jfhs_pkg::ST_NO_EOI;
      else hdr.status = parse_verdict;
      hdr.height = found ? cap_height : 16'd0;
      hdr.width  = found ? cap_width : 16'd0;
      hdr.c420   = found && (seg_marker == jfhs_pkg::MK_SOF0 ||
                             seg_marker == jfhs_pkg::MK_SOF2);
      hdr.marker = found ? seg_marker : 8'd0;
      due_headers.push_back(hdr);
      clear_walker();
    end
  endtask

  // image builders
  task automatic put(input logic [7:0] b);
    img.push_back(b);
  endtask

  task automatic put_marker(input logic [7:0] code);
    put(jfhs_pkg::MK_FF);
    put(code);
  endtask

  task automatic put_len(input logic [15:0] n);
    put(n[15:8]);
    put(n[7:0]);
  endtask

  task automatic put_noise(input int n);
    repeat (n) put(8'($urandom));
  endtask

  task automatic put_sof(input logic [7:0] code, input logic [15:0] len,
                         input logic [15:0] h, input logic [15:0] w, input int pad);
    put_marker(code);
    put_len(len);
    put(8'd8);
    put_len(h);
    put_len(w);
    put_noise(pad);
  endtask

  task automatic commit_image(input logic drain);
    for (int i = 0; i < img.size(); i++) begin
      byte_queue.push_back('{data: img[i], last: (i == img.size() - 1), drain: (drain && i == 0)});
    end
    total_bytes  += img.size();
    total_images += 1;
    img.delete();
  endtask

  function automatic logic [7:0] pick_segment_code();
    logic [7:0] c;
    do begin
      c = 8'($urandom);
    end while (c == jfhs_pkg::MK_FF || c == jfhs_pkg::MK_EOI || c == 8'h00 ||
               c == jfhs_pkg::MK_SOI || is_standalone(c) || is_sof_code(c));
    return c;
  endfunction

  function automatic logic [15:0] pick_dim();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // well-formed image with random content, then maybe broken on purpose
  task automatic build_random_image();
    logic [15:0] seg_len;
    int          cut;
    int          pick;
    put_marker(jfhs_pkg::MK_SOI);
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) put(jfhs_pkg::MK_FF);
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1) == 0) put_marker(jfhs_pkg::MK_TEM);
        else put_marker(jfhs_pkg::MK_RST0 + 8'($urandom_range(0, 7)));
      end
      put_marker(pick_segment_code());
      seg_len = 16'($urandom_range(2, 12));
      put_len(seg_len);
      put_noise(seg_len - 2);
    end
    seg_len = 16'($urandom_range(7, 17));
    put_sof(sof_codes[$urandom_range(0, 6)], seg_len, pick_dim(), pick_dim(), seg_len - 7);
    put_noise($urandom_range(0, 6));
    put_marker(jfhs_pkg::MK_EOI);
    pick = $urandom_range(0, 99);
    if (pick >= 90) begin
      // clobber the last byte, tail most likely gone
      img[img.size() - 1] = 8'($urandom);
    end else if (pick >= 80) begin
      // truncate anywhere, sometimes with a proper tail after the cut
      cut = $urandom_range(0, img.size() - 1);
      while (img.size() > cut + 1) void'(img.pop_back());
      if ($urandom_range(0, 1) == 0) put_marker(jfhs_pkg::MK_EOI);
    end else if (pick >= 70) begin
      img[$urandom_range(0, img.size() - 1)] = 8'($urandom);
    end
  endtask

  // stimulus: directed images first, then random ones
  initial begin : build_stimulus
    int n;
    clear_walker();
    // every frame code, extreme dimensions
    put_marker(jfhs_pkg::MK_SOI);
    put_sof(jfhs_pkg::MK_SOF0, 16'd7, 16'h0000, 16'h0000, 0);
    put_marker(jfhs_pkg::MK_EOI);
    commit_image(1'b0);
    put_marker(jfhs_pkg::MK_SOI);
    put_sof(jfhs_pkg::MK_SOF2, 16'd17, 16'hFFFF, 16'hFFFF, 10);
    put_marker(jfhs_pkg::MK_EOI);
    commit_image(1'b0);
    for (int i = 0; i < 7; i++) begin
      put_marker(jfhs_pkg::MK_SOI);
      put_sof(sof_codes[i], 16'd8, 16'($urandom), 16'($urandom), 1);
      put_noise(2);
      put_marker(jfhs_pkg::MK_EOI);
      commit_image(1'b0);
    end
    // one-byte images, both ends of the soi check
    put(jfhs_pkg::MK_EOI); commit_image(1'b0);
    put(jfhs_pkg::MK_FF); commit_image(1'b0);
    // bad second soi byte
    put(jfhs_pkg::MK_FF); put(8'h00); put_marker(jfhs_pkg::MK_EOI); commit_image(1'b0);
    // frame found but no eoi tail
    put_marker(jfhs_pkg::MK_SOI);
    put_sof(jfhs_pkg::MK_SOF1, 16'd11, 16'd480, 16'd640, 4);
    put(8'h00); put(jfhs_pkg::MK_EOI);
    commit_image(1'b0);
    // non-ff where a marker belongs
    put_marker(jfhs_pkg::MK_SOI); put(8'h12); put_marker(jfhs_pkg::MK_EOI); commit_image(1'b0);
    // marker code zero, then a second soi
    put_marker(jfhs_pkg::MK_SOI); put_marker(8'h00); put_marker(jfhs_pkg::MK_EOI);
    commit_image(1'b0);
    put_marker(jfhs_pkg::MK_SOI); put_marker(jfhs_pkg::MK_SOI); put_marker(jfhs_pkg::MK_EOI);
    commit_image(1'b0);
    // standalone markers and fill bytes ahead of the frame, empty segment
    put_marker(jfhs_pkg::MK_SOI); put_marker(jfhs_pkg::MK_TEM);
    put_marker(jfhs_pkg::MK_RST0); put_marker(jfhs_pkg::MK_RST7);
    put(jfhs_pkg::MK_FF); put(jfhs_pkg::MK_FF); put_marker(8'hE0); put_len(16'd2);
    put_sof(jfhs_pkg::MK_SOF3, 16'd7, 16'd1, 16'd1, 0); put_marker(jfhs_pkg::MK_EOI);
    commit_image(1'b0);
    // segment lengths below two
    put_marker(jfhs_pkg::MK_SOI); put_marker(8'hE0); put_len(16'd1);
    put_marker(jfhs_pkg::MK_EOI); commit_image(1'b0);
    put_marker(jfhs_pkg::MK_SOI); put_marker(8'hDB); put_len(16'd0);
    put_marker(jfhs_pkg::MK_EOI); commit_image(1'b0);
    // frame segment length below seven
    put_marker(jfhs_pkg::MK_SOI); put_sof(jfhs_pkg::MK_SOF0, 16'd6, 16'd8, 16'd8, 0);
    put_marker(jfhs_pkg::MK_EOI);
    commit_image(1'b0);
    // eoi before any frame
    put_marker(jfhs_pkg::MK_SOI); put_marker(jfhs_pkg::MK_EOI); commit_image(1'b0);
    // truncated inside a segment, inside the longest one, and inside the frame header
    put_marker(jfhs_pkg::MK_SOI); put_marker(8'hE0); put_len(16'd16); put(8'h01); put(8'h02);
    put_marker(jfhs_pkg::MK_EOI); commit_image(1'b0);
    put_marker(jfhs_pkg::MK_SOI); put_marker(8'hE1); put_len(16'hFFFF); put(8'h00);
    put_marker(jfhs_pkg::MK_EOI);
    commit_image(1'b0);
    put_marker(jfhs_pkg::MK_SOI); put_marker(jfhs_pkg::MK_SOF0); put_len(16'd17);
    put(8'd8); put(8'h01);
    put_marker(jfhs_pkg::MK_EOI); commit_image(1'b0);

    // random part: mostly well-formed images, some noise
    n = 0;
    while (total_bytes < TARGET_BYTES) begin
      if ($urandom_range(0, 99) < 5) put_noise($urandom_range(1, 6));
      else build_random_image();
      // now and then the sender waits for the block to drain first
      commit_image(n % 23 == 7);
      n++;
    end
  end

  // driver: offers queued bytes, predicts on every accepted request
  always @(posedge clk) begin : drive_bytes
    logic offer;
    int   ph;
    if (!rst_n) begin
      in_valid      <= 1'b0;
      in_data_byte  <= 8'h00;
      in_final_byte <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        scan_byte(in_data_byte, in_final_byte);
        void'(byte_queue.pop_front());
        bytes_sent <= bytes_sent + 1;
        if (in_final_byte) finals_sent <= finals_sent + 1;
      end
      // a request not yet taken stays put
      if (!(in_valid && !in_ready)) begin
        offer = 1'b0;
        ph    = bytes_sent * 3 / total_bytes;
        if (byte_queue.size() > 0) begin
          if (byte_queue[0].drain && due_headers.size() != 0) offer = 1'b0;
          else offer = $urandom_range(0, 99) >= idle_share(ph, 1'b1);
        end
        in_valid <= offer;
        if (offer) begin
          in_data_byte  <= byte_queue[0].data;
          in_final_byte <= byte_queue[0].last;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: mismatch on %s, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // monitor: checks each result request against the oldest expected header
  int hold_left      = 0;
  bit long_hold_done = 1'b0;

  always @(posedge clk) begin : watch_headers
    header_info_t want;
    int           ph;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (out_status <= jfhs_pkg::ST_NOFRAME) status_hits[out_status]++;
        if (due_headers.size() == 0) begin
          $display("%0t ns: result request with no header pending, status %0d",
                   $time, out_status);
          errors++;
        end else begin
          want = due_headers.pop_front();
          check_field("status", 16'(want.status), 16'(out_status));
          check_field("frame_height", want.height, out_frame_height);
          check_field("frame_width", want.width, out_frame_width);
          check_field("chroma_420", 16'(want.c420), 16'(out_chroma_420));
          check_field("frame_marker", 16'(want.marker), 16'(out_frame_marker));
        end
      end
      // one long hold-off early in the run, so the queue backs up into in_ready
      ph = results_seen * 3 / total_images;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 12) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD;
        out_ready <= 1'b0;
      end else begin
        out_ready <= $urandom_range(0, 99) >= idle_share(ph, 1'b0);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d bytes sent, %0d results",
               cycle_count, bytes_sent, total_bytes, results_seen);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // end of run: all bytes in, all headers back, then a short settle
  initial begin : finish_run
    wait (rst_n === 1'b1);
    while (bytes_sent != total_bytes || finals_sent != results_seen) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (due_headers.size() != 0) begin
      $display("%0t ns: %0d expected headers never arrived", $time, due_headers.size());
      errors++;
    end
    $display("scanned %0d images in %0d bytes, %0d results checked, %0d errors",
             total_images, total_bytes, results_seen, errors);
    $display("status mix: ok %0d, no soi %0d, no eoi %0d, bad %0d, early eoi %0d, no frame %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             status_hits[4], status_hits[5]);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
